FILE: rtl/rmsn_pkg.sv
// Shared constants, state types and control and status structs for the RMS error block.
`default_nettype none

package rmsn_pkg;

	// Field and register widths
	localparam int MAX_CELLS    = 1048576;
	localparam int SAMPLE_WIDTH = 16;
	localparam int IN_W         = 16;
	localparam int DIFF_W       = IN_W + 1;
	localparam int MAG_W        = IN_W;
	localparam int SQ_W         = 2 * MAG_W;
	localparam int COUNT_W      = $clog2(MAX_CELLS) + 1;
	localparam int SUM_W        = 54;
	localparam int RMS_W        = 16;

	// Divide and root sequencing
	localparam int DIV_STEPS  = SUM_W;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQR,
		ST_ADD,
		ST_ROOT
	} rmsn_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DIV,
		DS_SQRT,
		DS_DONE
	} rmsn_ds_state_t;

	typedef struct packed {
		logic start;
		logic take;
	} rmsn_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rmsn_sts_t;

endpackage

`default_nettype wire

FILE: rtl/rmsn_divsqrt.sv
// Sequential divide followed by integer square root on one shared subtractor.
`default_nettype none

module rmsn_divsqrt
	import rmsn_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rmsn_ctl_t            ctl,
	input  wire logic [SUM_W-1:0]     dividend,
	input  wire logic [COUNT_W-1:0]   divisor,
	output rmsn_sts_t                 sts,
	output logic      [RMS_W-1:0]     root
);

	rmsn_ds_state_t       state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     num_q;
	logic [COUNT_W-1:0]   div_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;

	// Shared trial subtractor
	logic [REM_W-1:0]     opa, opb;
	logic [REM_W:0]       diff;
	logic                 fits;

	always_comb begin
		if (state_q == DS_SQRT) begin
			opa = {rem_q[REM_W-3:0], num_q[SUM_W-1 -: 2]};
			opb = {1'b0, root_q, 2'b01};
		end else begin
			opa = {rem_q[REM_W-2:0], num_q[SUM_W-1]};
			opb = {{(REM_W-COUNT_W){1'b0}}, div_q};
		end
		diff = {1'b0, opa} - {1'b0, opb};
		fits = ~diff[REM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sts.busy = (state_q != DS_IDLE);
		sts.done = (state_q == DS_DONE);
		unique case (state_q)
			DS_IDLE: begin
				if (ctl.start) state_d = DS_DIV;
			end
			DS_DIV: begin
				if (cnt_q == '0) state_d = DS_SQRT;
			end
			DS_SQRT: begin
				if (cnt_q == '0) state_d = DS_DONE;
			end
			DS_DONE: begin
				if (ctl.take) state_d = DS_IDLE;
			end
			default: state_d = DS_IDLE;
		endcase
	end

	// Datapath: quotient shifts into the numerator register, then the root
	// consumes it two bits a step.
	always_ff @(posedge clk) begin
		unique case (state_q)
			DS_IDLE: begin
				if (ctl.start) begin
					num_q  <= dividend;
					div_q  <= divisor;
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CNT_W'(DIV_STEPS - 1);
				end
			end
			DS_DIV: begin
				num_q <= {num_q[SUM_W-2:0], fits};
				if (cnt_q == '0) begin
					// Drop the division remainder before the root starts.
					rem_q <= '0;
					cnt_q <= CNT_W'(SQRT_STEPS - 1);
				end else begin
					rem_q <= fits ? diff[REM_W-1:0] : opa;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			DS_SQRT: begin
				rem_q  <= fits ? diff[REM_W-1:0] : opa;
				num_q  <= {num_q[SUM_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
			end
			DS_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Saturate the root to the output field.
	assign root = (root_q[ROOT_W-1:RMS_W] != '0) ? {RMS_W{1'b1}} : root_q[RMS_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/rms_error_norm.sv
// Top level of the RMS error block: accumulate squared differences, then divide and root.
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_ready  | sample_a, sample_b, last_cell
//  out     | output    | out_valid / out_ready| rms_error
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (cell_count)
//
//  An input request is handled in order: capture the difference, square it on the
//  16x16 multiplier, add it into the 54-bit sum. A request marked last then runs
//  in the shared subtractor: 54 restoring divide steps by cell_count, 27 root
//  steps, then the root is handed over. Reset clears the sum and sets
//  cell_count to 1. A waiting result holds in the output register while the
//  next run accumulates; a second root stalls only if that result is still
//  untaken.

module rms_error_norm
	import rmsn_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [IN_W-1:0]     sample_a,
	input  wire logic [IN_W-1:0]     sample_b,
	input  wire logic                last_cell,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [RMS_W-1:0]    rms_error,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [COUNT_W-1:0]  cfg_data
);

	rmsn_state_t          state_q, state_d;
	logic [COUNT_W-1:0]   cell_count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [MAG_W-1:0]     mag_q;
	logic                 last_q;
	logic [SQ_W-1:0]      sq_q;
	logic                 out_valid_q;
	logic [RMS_W-1:0]     rms_q;

	logic [DIFF_W-1:0]    a_ext, b_ext, diff, diff_neg;
	logic [MAG_W-1:0]     mag;
	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     sum_sat;
	logic [COUNT_W-1:0]   divisor;
	logic                 accept;
	logic                 load_out;

	rmsn_ctl_t            ctl;
	rmsn_sts_t            sts;
	logic [RMS_W-1:0]     root;

	// Use only the low SAMPLE_WIDTH bits of each sample, sign-extended.
	assign a_ext    = {{(DIFF_W-SAMPLE_WIDTH){sample_a[SAMPLE_WIDTH-1]}},
	                   sample_a[SAMPLE_WIDTH-1:0]};
	assign b_ext    = {{(DIFF_W-SAMPLE_WIDTH){sample_b[SAMPLE_WIDTH-1]}},
	                   sample_b[SAMPLE_WIDTH-1:0]};
	assign diff     = a_ext - b_ext;
	assign diff_neg = -diff;
	assign mag      = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

	// Saturating accumulate: pin at all ones instead of wrapping.
	assign sum_wide = {1'b0, sum_q} + {{(SUM_W+1-SQ_W){1'b0}}, sq_q};
	assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

	// A zero cell count divides as one.
	assign divisor  = (cell_count_q == '0) ? COUNT_W'(1) : cell_count_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign rms_error = rms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl.start = 1'b0;
		ctl.take  = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SQR;
			end
			ST_SQR: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				// Kick off divide and root on the last cell of a field.
				if (last_q) begin
					ctl.start = 1'b1;
					state_d   = ST_ROOT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ROOT: begin
				// Hold the root until the output register is free.
				if (sts.done && (!out_valid_q || out_ready)) begin
					ctl.take = 1'b1;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers: config, running sum, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= COUNT_W'(1);
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) cell_count_q <= cfg_data;
			if (state_q == ST_ADD) begin
				sum_q <= last_q ? '0 : sum_sat;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= mag;
			last_q <= last_cell;
		end
		if (state_q == ST_SQR) sq_q <= mag_q * mag_q;
		if (load_out) rms_q <= root;
	end

	rmsn_divsqrt u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.dividend (sum_sat),
		.divisor  (divisor),
		.sts      (sts),
		.root     (root)
	);

	// The root unit is idle whenever a new request can enter.
	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.busy)
		else $error("root unit busy while input is ready");

	// A start always launches the root unit.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> sts.busy)
		else $error("root unit did not start");

	// A result is only taken from a finished root.
	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |-> sts.done)
		else $error("result taken before root finished");

	// A new result appears only after the root wait state.
	a_out_from_root: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ROOT))
		else $error("result raised outside root state");

endmodule

`default_nettype wire
